// ===== rtl/core/nibble_rle_encoder_assert.svh =====
// Assertion macros shared by the nibble RLE encoder modules
`ifndef NIBBLE_RLE_ENCODER_ASSERT_SVH
`define NIBBLE_RLE_ENCODER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define NRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nre: same-cycle check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define NRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nre: next-cycle check failed");

`endif

// ===== rtl/core/nre_pkg.sv =====
// Shared types and constants for the nibble RLE encoder
package nre_pkg;

    localparam int SYM_W           = 4;
    localparam int LEN_W           = 5;
    localparam int BYTE_W          = 8;
    localparam int LONGEST_RUN_DEF = 17;
    localparam int FIFO_DEPTH      = 4;

    localparam logic MODE_SYMBOL = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct packed {
        logic [1:0]        nbytes;
        logic [BYTE_W-1:0] data0;
        logic [BYTE_W-1:0] data1;
    } t_enc_out;

endpackage

// ===== rtl/core/nre_encode.sv =====
// Run tracking, nibble sequencing and byte packing for one transaction
`include "nibble_rle_encoder_assert.svh"

module nre_encode import nre_pkg::*; #(
    parameter int LONGEST_RUN = LONGEST_RUN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_mode,
    input  logic [SYM_W-1:0] i_symbol,
    output t_enc_out         o_res
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LONGEST_RUN);

    logic [SYM_W-1:0] r_run_symbol, n_run_symbol;
    logic [LEN_W-1:0] r_run_length, n_run_length;
    logic [SYM_W-1:0] r_held_nibble, n_held_nibble;
    logic             r_held_valid, n_held_valid;

    logic             flush;
    logic             close;
    logic [LEN_W-1:0] len_m2;
    logic [SYM_W-1:0] nib [4];
    logic [2:0]       k;

    assign len_m2 = r_run_length - LEN_W'(2);

    always_comb begin
        flush = (i_mode == MODE_FLUSH);
        close = flush || (i_symbol != r_run_symbol) || (r_run_length >= MAX_LEN);
        for (int i = 0; i < 4; i++) begin
            nib[i] = '0;
        end
        k = 3'd0;
        if (r_held_valid) begin
            nib[0] = r_held_nibble;
            k      = 3'd1;
        end
        if (close && r_run_length >= LEN_W'(1)) begin
            nib[k[1:0]] = r_run_symbol;
            k           = k + 3'd1;
        end
        if (close && r_run_length >= LEN_W'(2)) begin
            nib[k[1:0]] = r_run_symbol;
            k           = k + 3'd1;
        end
        if (close && r_run_length >= LEN_W'(3)) begin
            nib[k[1:0]] = len_m2[SYM_W-1:0];
            k           = k + 3'd1;
        end
        // pad a dangling nibble on flush
        if (flush && k[0]) begin
            nib[k[1:0]] = '0;
            k           = k + 3'd1;
        end

        o_res.nbytes = k[2:1];
        o_res.data0  = {nib[1], nib[0]};
        o_res.data1  = {nib[3], nib[2]};

        n_held_valid  = k[0];
        n_held_nibble = r_held_nibble;
        if (k[0]) begin
            n_held_nibble = k[1] ? nib[2] : nib[0];
        end

        n_run_symbol = r_run_symbol;
        n_run_length = '0;
        if (!flush) begin
            n_run_symbol = i_symbol;
            n_run_length = (close ? '0 : r_run_length) + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_symbol  <= '0;
            r_run_length  <= '0;
            r_held_nibble <= '0;
            r_held_valid  <= 1'b0;
        end else if (i_fire) begin
            r_run_symbol  <= n_run_symbol;
            r_run_length  <= n_run_length;
            r_held_nibble <= n_held_nibble;
            r_held_valid  <= n_held_valid;
        end
    end

    `NRE_ASSERT_NOW(a_len_bound, 1'b1, r_run_length <= MAX_LEN)
    `NRE_ASSERT_NEXT(a_flush_clears, i_fire && flush, !r_held_valid && r_run_length == '0)

endmodule

// ===== rtl/core/nre_ofifo.sv =====
// Output byte queue, up to two writes and one read per cycle, the read only when not stalled
`include "nibble_rle_encoder_assert.svh"

module nre_ofifo import nre_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_enc_out          i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_last,
    output logic              o_room
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

    logic [BYTE_W-1:0] r_mem_data [FIFO_DEPTH];
    logic              r_mem_last [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  push_n;
    logic              pop;
    logic [PTR_W-1:0]  wr_p1;

    assign push_n  = i_fire ? CNT_W'(i_res.nbytes) : '0;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= DEPTH_C - CNT_W'(2));
    assign o_data  = r_mem_data[r_rd];
    assign o_last  = r_mem_last[r_rd];
    assign wr_p1   = r_wr + PTR_W'(1);
    assign n_wr    = r_wr + PTR_W'(push_n);
    assign n_rd    = r_rd + PTR_W'(pop);
    assign n_count = r_count + push_n - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res.nbytes != 2'd0) begin
            r_mem_data[r_wr] <= i_res.data0;
            r_mem_last[r_wr] <= (i_res.nbytes == 2'd1);
        end
        if (i_fire && i_res.nbytes == 2'd2) begin
            r_mem_data[wr_p1] <= i_res.data1;
            r_mem_last[wr_p1] <= 1'b1;
        end
    end

    `NRE_ASSERT_NOW(a_cnt_bound, 1'b1, r_count <= DEPTH_C)
    `NRE_ASSERT_NOW(a_no_overrun, i_fire, o_room && i_res.nbytes != 2'd3)

endmodule

// ===== rtl/core/nibble_rle_encoder.sv =====
// Top level of the nibble run-length encoder
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------
//  input    | i_in_valid / o_in_stall   | i_mode, i_symbol
//  output   | o_out_valid / i_out_stall | o_out_byte, o_last
//
// A transaction is registered, then encoded combinationally into 0 to 2 bytes
// that go into a four-entry output queue. The output port moves one byte per
// cycle when not stalled, so sustained rate is one transaction per cycle when
// each yields at most one byte and is bound by the output port when each
// yields two. Input stalls while the queue has fewer than two free entries.
// Synchronous reset clears run state and the queue.
module nibble_rle_encoder import nre_pkg::*; #(
    parameter int LONGEST_RUN = LONGEST_RUN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_mode,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    logic             r_in_valid;
    logic             r_in_mode;
    logic [SYM_W-1:0] r_in_symbol;
    logic             room;
    logic             fire;
    t_enc_out         res;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_mode   <= i_mode;
            r_in_symbol <= i_symbol;
        end
    end

    nre_encode #(
        .LONGEST_RUN (LONGEST_RUN)
    ) u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_mode   (r_in_mode),
        .i_symbol (r_in_symbol),
        .o_res    (res)
    );

    nre_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_byte),
        .o_last  (o_last),
        .o_room  (room)
    );

endmodule

// ===== bench/nibble_rle_encoder_tb.sv =====
// Self-checking testbench for the nibble run-length encoder
`timescale 1ns / 100ps

module nibble_rle_encoder_tb;
    import nre_pkg::*;

    localparam int RUN_LIMIT = LONGEST_RUN_DEF;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte_due;

    typedef struct {
        logic             mode;
        logic [SYM_W-1:0] sym;
        int               reps;
        bit               typed;
        int               nbytes;
        logic [7:0]       b0;
        logic [7:0]       b1;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic              i_mode      = MODE_SYMBOL;
    logic [SYM_W-1:0]  i_symbol    = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last;

    // encoder state as predicted
    logic [SYM_W-1:0] run_sym  = '0;
    logic [LEN_W-1:0] run_len  = '0;
    logic [SYM_W-1:0] held_nib = '0;
    bit               held_ok  = 1'b0;

    t_byte_due coded_bytes_due[$];
    int        errors         = 0;
    int        burst_left     = 0;
    int        long_hold_req  = 0;

    nibble_rle_encoder #(.LONGEST_RUN(RUN_LIMIT)) i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_nibble(input logic [SYM_W-1:0] v, inout int n,
                               inout logic [1:0][7:0] coded);
        if (held_ok) begin
            coded[n] = {v, held_nib};
            n++;
            held_ok = 1'b0;
        end else begin
            held_nib = v;
            held_ok  = 1'b1;
        end
    endtask

    task automatic close_open_run(inout int n, inout logic [1:0][7:0] coded);
        if (run_len > 0) begin
            push_nibble(run_sym, n, coded);
            if (run_len > 1) begin
                push_nibble(run_sym, n, coded);
                if (run_len > 2)
                    push_nibble(SYM_W'(run_len - 2), n, coded);
            end
        end
        run_len = '0;
    endtask

    task automatic rle_encode(input logic m, input logic [SYM_W-1:0] s, output int n,
                              output logic [1:0][7:0] coded);
        n     = 0;
        coded = '0;
        if (m == MODE_FLUSH) begin
            close_open_run(n, coded);
            if (held_ok)
                push_nibble('0, n, coded);
        end else begin
            if (s != run_sym || run_len >= RUN_LIMIT)
                close_open_run(n, coded);
            run_sym = s;
            run_len = run_len + 1'b1;
        end
    endtask

    task automatic offer_item(input logic m, input logic [SYM_W-1:0] s, input bit typed,
                              input int tn, input logic [1:0][7:0] tb);
        int               n;
        logic [1:0][7:0]  coded;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_symbol   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rle_encode(m, s, n, coded);
        if (typed) begin
            n     = tn;
            coded = tb;
        end
        for (int i = 0; i < n; i++)
            coded_bytes_due.insert(coded_bytes_due.size(),
                                   t_byte_due'{coded[i], i == n - 1});
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (coded_bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        burst_left = 0;
    endtask

    // receiver: stall density changes per segment, plus an occasional long hold
    initial begin
        int seg_left;
        int pct;
        int hold_left;
        int holds_done;
        seg_left   = 0;
        pct        = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 60;
                    default: pct = 90;
                endcase
                seg_left = $urandom_range(32, 200);
            end
            seg_left--;
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (long_hold_req != holds_done) begin
                holds_done++;
                hold_left     = 119;
                i_out_stall  <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_byte_due due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (coded_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b", $time, o_out_byte, o_last);
                errors++;
            end else begin
                due = coded_bytes_due.pop_front();
                if (o_out_byte !== due.data || o_last !== due.last) begin
                    $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                             $time, due.data, due.last, o_out_byte, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_stim_row        directed [14];
        int               made;
        int               len;
        int               guard;
        int               stage;
        int               lost;
        logic [SYM_W-1:0] sym;

        directed = '{
            '{MODE_FLUSH,  4'h0, 1,  1, 0, 8'h00, 8'h00},
            '{MODE_SYMBOL, 4'h0, 1,  1, 0, 8'h00, 8'h00},
            '{MODE_FLUSH,  4'hF, 1,  1, 1, 8'h00, 8'h00},
            '{MODE_SYMBOL, 4'hF, 2,  0, 0, 8'h00, 8'h00},
            '{MODE_FLUSH,  4'h0, 1,  1, 1, 8'hFF, 8'h00},
            '{MODE_SYMBOL, 4'h5, 3,  0, 0, 8'h00, 8'h00},
            '{MODE_FLUSH,  4'h0, 1,  1, 2, 8'h55, 8'h01},
            '{MODE_SYMBOL, 4'hA, 17, 0, 0, 8'h00, 8'h00},
            '{MODE_SYMBOL, 4'hA, 1,  1, 1, 8'hAA, 8'h00},
            '{MODE_FLUSH,  4'h6, 1,  1, 1, 8'hAF, 8'h00},
            '{MODE_SYMBOL, 4'hA, 1,  0, 0, 8'h00, 8'h00},
            '{MODE_SYMBOL, 4'h3, 1,  0, 0, 8'h00, 8'h00},
            '{MODE_SYMBOL, 4'hC, 1,  0, 0, 8'h00, 8'h00},
            '{MODE_FLUSH,  4'h9, 1,  0, 0, 8'h00, 8'h00}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed[r])
            for (int k = 0; k < directed[r].reps; k++)
                offer_item(directed[r].mode, directed[r].sym,
                           directed[r].typed && k == directed[r].reps - 1,
                           directed[r].nbytes, {directed[r].b1, directed[r].b0});
        wait_drained();

        made  = 0;
        stage = 0;
        while (made < 410) begin
            if (stage == 0 && made >= 120) begin
                long_hold_req++;
                stage = 1;
            end else if (stage == 1 && made >= 250) begin
                wait_drained();
                stage = 2;
            end else if (stage == 2 && made >= 360) begin
                long_hold_req++;
                stage = 3;
            end
            if ($urandom_range(0, 9) == 0) begin
                offer_item(MODE_FLUSH, SYM_W'($urandom_range(0, 15)), 1'b0, 0, '0);
                made++;
            end else begin
                sym = SYM_W'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = $urandom_range(1, 3);
                    5, 6, 7:       len = $urandom_range(4, 15);
                    8:             len = $urandom_range(16, 18);
                    default:       len = $urandom_range(19, 40);
                endcase
                repeat (len) offer_item(MODE_SYMBOL, sym, 1'b0, 0, '0);
                made += len;
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (coded_bytes_due.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
        lost = coded_bytes_due.size();
        if (lost != 0)
            $display("%0t: %0d expected bytes never arrived, next %02h last %0b", $time,
                     lost, coded_bytes_due[0].data, coded_bytes_due[0].last);
        if (errors == 0 && lost == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
